>>> rtl/core/rrt_pkg.sv
// rrt_pkg: shared types and codes for the receive reorder tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrt_pkg;

	typedef enum logic [0:0] {
		CMP_GT      = 1'b0,
		CMP_STEP_EQ = 1'b1
	} cmp_op_t;

	typedef struct packed {
		logic       rotate;
		logic       pop;
		logic [7:0] tail;
	} list_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/rrt_cmp_unit.sv
// rrt_cmp_unit: shared compare unit, greater-than or step-sum equality
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrt_cmp_unit (
	input  wire logic            [7:0] a,
	input  wire logic            [7:0] b,
	input  wire logic            [7:0] step,
	input  wire rrt_pkg::cmp_op_t      op,
	output logic                       hit
);

	logic [8:0] sum;

	assign sum = {1'b0, a} + {1'b0, step};

	always_comb begin
		unique case (op)
			rrt_pkg::CMP_GT:      hit = (a > b);
			rrt_pkg::CMP_STEP_EQ: hit = (sum == {1'b0, b});
			default:              hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/rrt_list.sv
// rrt_list: sorted list storage as a rotating shift line with pop-down
// depends on rrt_pkg
`timescale 1ns / 1ps
`default_nettype none

module rrt_list #(
	parameter int DEPTH = 8
) (
	input  wire logic                 clk,
	input  wire rrt_pkg::list_ctrl_t  ctrl,
	output logic                [7:0] head,
	output logic                [7:0] second
);

	logic [7:0] held_q [DEPTH];

	always_ff @(posedge clk) begin
		if (ctrl.rotate) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				held_q[i] <= held_q[i + 1];
			end
			held_q[DEPTH - 1] <= ctrl.tail;
		end else if (ctrl.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				held_q[i] <= held_q[i + 1];
			end
		end
	end

	assign head   = held_q[0];
	assign second = held_q[1];

endmodule

`default_nettype wire

>>> rtl/core/receive_reorder_tracker_unit.sv
// receive_reorder_tracker_unit: top level, sequencer around the list and compare unit
// depends on rrt_pkg, rrt_cmp_unit, rrt_list
// from start to done: one full rotation of the list through the shared comparator, then head removals
// a full list drops the item and reports overflow in the cycle after start
// a new item is taken only while idle, so not before the previous one is done
// dropped items on a full list can follow every cycle
// reset clears the count, the step register (to 1) and the sequencer; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none

module receive_reorder_tracker_unit #(
	parameter int LIST_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [7:0] seq_num,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	output logic            done,
	output logic      [7:0] ack_seq,
	output logic      [3:0] held_count,
	output logic            overflow
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int RW = $clog2(LIST_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_INS  = 3'b010,
		ST_POP  = 3'b100
	} state_t;

	state_t              state_q;
	logic     [CW-1:0]   count_q;
	logic     [RW-1:0]   rot_q;
	logic     [7:0]      carry_q;
	logic                ins_q;
	logic     [7:0]      step_q;
	logic                done_q;
	logic     [7:0]      ack_q;
	logic     [CW-1:0]   cnt_out_q;
	logic                ovf_q;

	rrt_pkg::list_ctrl_t ctrl;
	rrt_pkg::cmp_op_t    op;
	logic     [7:0]      head;
	logic     [7:0]      second;
	logic     [7:0]      cmp_b;
	logic                hit;
	logic     [CW-1:0]   rot_ext;
	logic                full;
	logic                can_pop;
	logic     [CW+3:0]   cnt_wide;

	assign rot_ext  = CW'(rot_q);
	assign full     = (count_q == CW'(LIST_DEPTH));
	assign can_pop  = (count_q >= CW'(2)) && hit;

	rrt_list #(
		.DEPTH (LIST_DEPTH)
	) u_list (
		.clk    (clk),
		.ctrl   (ctrl),
		.head   (head),
		.second (second)
	);

	rrt_cmp_unit u_cmp (
		.a    (head),
		.b    (cmp_b),
		.step (step_q),
		.op   (op),
		.hit  (hit)
	);

	always_comb begin
		op          = rrt_pkg::CMP_GT;
		cmp_b       = carry_q;
		ctrl.rotate = 1'b0;
		ctrl.pop    = 1'b0;
		ctrl.tail   = head;
		unique case (state_q)
			ST_INS: begin
				ctrl.rotate = 1'b1;
				if (rot_ext < count_q) begin
					if (ins_q || hit) begin
						ctrl.tail = carry_q;
					end
				end else if (rot_ext == count_q) begin
					ctrl.tail = carry_q;
				end
			end
			ST_POP: begin
				op       = rrt_pkg::CMP_STEP_EQ;
				cmp_b    = second;
				ctrl.pop = can_pop;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rot_q   <= '0;
			ins_q   <= 1'b0;
			step_q  <= 8'd1;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				step_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (full) begin
							done_q <= 1'b1;
						end else begin
							rot_q   <= '0;
							ins_q   <= 1'b0;
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					if ((rot_ext < count_q) && (ins_q || hit)) begin
						ins_q <= 1'b1;
					end
					if (rot_q == RW'(LIST_DEPTH - 1)) begin
						count_q <= count_q + CW'(1);
						state_q <= ST_POP;
					end else begin
						rot_q <= rot_q + RW'(1);
					end
				end
				ST_POP: begin
					if (can_pop) begin
						count_q <= count_q - CW'(1);
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					carry_q <= seq_num;
				end
				ack_q     <= head;
				cnt_out_q <= count_q;
				ovf_q     <= full;
			end
			ST_INS: begin
				if ((rot_ext < count_q) && (ins_q || hit)) begin
					carry_q <= head;
				end
			end
			ST_POP: begin
				ack_q     <= head;
				cnt_out_q <= count_q;
				ovf_q     <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign cnt_wide   = {4'b0000, cnt_out_q};
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign ack_seq    = ack_q;
	assign held_count = cnt_wide[3:0];
	assign overflow   = ovf_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(LIST_DEPTH))
		else $error("list count above depth");

	a_ins_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (count_q < CW'(LIST_DEPTH)))
		else $error("insert started on a full list");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result while an item is in progress");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ovf_q) |-> full)
		else $error("overflow reported with room in list");

	a_pop_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> (count_q >= CW'(2)))
		else $error("pop with fewer than two entries");
`endif

endmodule

`default_nettype wire
